// ===== hw/rtl/periodic_timer_table_top_macros.svh =====
// Assertion macros for the periodic timer table.
`ifndef PERIODIC_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_TIMER_TABLE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTT_ASSERT_ON(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);
`define PTT_ASSERT(lbl, prop, msg) \
    `PTT_ASSERT_ON(lbl, clk, rst_n, prop, msg)
`else
`define PTT_ASSERT_ON(lbl, clk_sig, rst_sig, prop, msg)
`define PTT_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/ptt_pkg.sv =====
// Shared types and constants of the periodic timer table.
`default_nettype none
package ptt_pkg;
    localparam int NUM_TIMERS     = 8;
    localparam int MAX_EXTRA_HITS = 7;
    localparam int ID_W           = 3;
    localparam int SIZE_W         = $clog2(NUM_TIMERS + 1);
    localparam int HIT_W          = 3;
    localparam int TIME_W         = 32;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ARM      = 3'd1;
    localparam logic [2:0] OP_SET_IVAL = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_RESTART  = 3'd4;
    localparam logic [2:0] OP_PAUSE    = 3'd5;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRE   = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(NUM_TIMERS);
    localparam logic [HIT_W-1:0]  HIT_MAX  = HIT_W'(MAX_EXTRA_HITS);

    typedef struct packed {
        logic              due;
        logic [TIME_W-1:0] next_last;
    } due_t;
endpackage
`default_nettype wire

// ===== hw/rtl/periodic_timer_table_top.sv =====
// Periodic timer table: a status result arrives in the cycle after an operation transfer, and
// the block takes a new operation in the next cycle.
// A tick walks the usable channels and their catch-up checks (one shared compare per cycle),
// with at most one fire event per cycle; busy stays high until the final result of the tick.
// Results are one-cycle strobes on done; the receiver cannot stall them.
// Asynchronous active-low reset clears every channel and sets timers_in_use to 8.
`default_nettype none
module periodic_timer_table_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [2:0]                  operation,
    input  wire logic [ptt_pkg::ID_W-1:0]    timer_id,
    input  wire logic                        all_timers,
    input  wire logic [ptt_pkg::TIME_W-1:0]  now_time,
    input  wire logic [ptt_pkg::TIME_W-1:0]  interval,
    input  wire logic                        catch_up,
    input  wire logic [2:0]                  extra_hits,
    input  wire logic                        pause_flag,
    output logic                             done,
    output logic [1:0]                       kind,
    output logic                             ok,
    output logic [ptt_pkg::ID_W-1:0]         fired_channel,
    output logic [ptt_pkg::TIME_W-1:0]       fire_time,
    output logic                             last
);
    logic [3:0] tiu_reg, tiu_next;
    logic       wr_en;

    // register 0 covers byte addresses 0 to 3
    assign wr_en    = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign tiu_next = wr_en ? pwdata[3:0] : tiu_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {28'd0, tiu_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiu_reg <= 4'(ptt_pkg::NUM_TIMERS);
        end
        else
        begin
            tiu_reg <= tiu_next;
        end
    end

    ptt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .timers_in_use (tiu_reg),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .timer_id      (timer_id),
        .all_timers    (all_timers),
        .now_time      (now_time),
        .interval      (interval),
        .catch_up      (catch_up),
        .extra_hits    (extra_hits),
        .pause_flag    (pause_flag),
        .done          (done),
        .kind          (kind),
        .ok            (ok),
        .fired_channel (fired_channel),
        .fire_time     (fire_time),
        .last          (last)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/ptt_due_unit.sv =====
// Shared elapsed-time compare and last-fire advance unit.
`default_nettype none
module ptt_due_unit (
    input  wire logic [ptt_pkg::TIME_W-1:0] now_time,
    input  wire logic [ptt_pkg::TIME_W-1:0] prev_fire,
    input  wire logic [ptt_pkg::TIME_W-1:0] period,
    output ptt_pkg::due_t                   result
);
    logic [ptt_pkg::TIME_W-1:0] elapsed;

    // wrapping difference, then compare against the period
    assign elapsed          = now_time - prev_fire;
    assign result.due       = (elapsed >= period);
    assign result.next_last = prev_fire + period;
endmodule
`default_nettype wire

// ===== hw/rtl/ptt_ctrl.sv =====
// Channel table and sequencer of the periodic timer table.
`default_nettype none
`include "periodic_timer_table_top_macros.svh"
module ptt_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [3:0]                  timers_in_use,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [2:0]                  operation,
    input  wire logic [ptt_pkg::ID_W-1:0]    timer_id,
    input  wire logic                        all_timers,
    input  wire logic [ptt_pkg::TIME_W-1:0]  now_time,
    input  wire logic [ptt_pkg::TIME_W-1:0]  interval,
    input  wire logic                        catch_up,
    input  wire logic [2:0]                  extra_hits,
    input  wire logic                        pause_flag,
    output logic                             done,
    output logic [1:0]                       kind,
    output logic                             ok,
    output logic [ptt_pkg::ID_W-1:0]         fired_channel,
    output logic [ptt_pkg::TIME_W-1:0]       fire_time,
    output logic                             last
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_CATCH  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    localparam int N = ptt_pkg::NUM_TIMERS;

    logic [1:0] state_reg, state_next;
    logic [ptt_pkg::ID_W-1:0]   idx_reg, idx_next;
    logic [ptt_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [ptt_pkg::HIT_W-1:0]  hit_reg, hit_next;
    logic [ptt_pkg::TIME_W-1:0] now_reg, now_next;
    logic pend_valid_reg, pend_valid_next;
    logic [ptt_pkg::ID_W-1:0]   pend_chan_reg, pend_chan_next;

    logic [N-1:0] armed_reg, armed_next;
    logic [N-1:0] paused_reg, paused_next;
    logic [N-1:0] catch_reg, catch_next;
    logic [ptt_pkg::TIME_W-1:0] period_reg [N];
    logic [ptt_pkg::TIME_W-1:0] period_next [N];
    logic [ptt_pkg::TIME_W-1:0] lastf_reg [N];
    logic [ptt_pkg::TIME_W-1:0] lastf_next [N];
    logic [ptt_pkg::HIT_W-1:0]  limit_reg [N];
    logic [ptt_pkg::HIT_W-1:0]  limit_next [N];

    logic done_reg, done_next;
    logic [1:0] kind_reg, kind_next;
    logic ok_reg, ok_next;
    logic [ptt_pkg::ID_W-1:0]   chan_reg, chan_next;
    logic [ptt_pkg::TIME_W-1:0] time_reg, time_next;
    logic last_reg, last_next;

    logic [ptt_pkg::SIZE_W-1:0] usable;
    logic [ptt_pkg::SIZE_W-1:0] idx_ext;
    logic [ptt_pkg::SIZE_W-1:0] id_ext;
    logic [ptt_pkg::HIT_W-1:0]  eh_sat;
    ptt_pkg::due_t              unit_res;
    logic fire_evt;
    logic advance;
    logic op_ok;

    assign usable  = (timers_in_use > 4'(ptt_pkg::SIZE_MAX)) ? ptt_pkg::SIZE_MAX
                                                             : ptt_pkg::SIZE_W'(timers_in_use);
    assign idx_ext = ptt_pkg::SIZE_W'(idx_reg);
    assign id_ext  = ptt_pkg::SIZE_W'(timer_id);
    assign eh_sat  = (extra_hits > 3'(ptt_pkg::HIT_MAX)) ? ptt_pkg::HIT_MAX
                                                         : ptt_pkg::HIT_W'(extra_hits);

    ptt_due_unit u_due (
        .now_time  (now_reg),
        .prev_fire (lastf_reg[idx_reg]),
        .period    (period_reg[idx_reg]),
        .result    (unit_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        size_next       = size_reg;
        hit_next        = hit_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_chan_next  = pend_chan_reg;
        armed_next      = armed_reg;
        paused_next     = paused_reg;
        catch_next      = catch_reg;
        period_next     = period_reg;
        lastf_next      = lastf_reg;
        limit_next      = limit_reg;
        done_next       = 1'b0;
        kind_next       = kind_reg;
        ok_next         = ok_reg;
        chan_next       = chan_reg;
        time_next       = time_reg;
        last_next       = last_reg;
        fire_evt        = 1'b0;
        advance         = 1'b0;
        op_ok           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == ptt_pkg::OP_TICK)
                    begin
                        now_next        = now_time;
                        size_next       = usable;
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = (usable == '0) ? S_FINISH : S_SCAN;
                    end
                    else
                    begin
                        if (operation > ptt_pkg::OP_PAUSE)
                        begin
                            op_ok = 1'b0;
                        end
                        else if (all_timers && operation >= ptt_pkg::OP_CLEAR)
                        begin
                            op_ok = 1'b1;
                            for (int i = 0; i < N; i++)
                            begin
                                if (ptt_pkg::SIZE_W'(i) < usable)
                                begin
                                    if (operation == ptt_pkg::OP_CLEAR)
                                    begin
                                        armed_next[i]  = 1'b0;
                                        paused_next[i] = 1'b0;
                                        catch_next[i]  = 1'b0;
                                        period_next[i] = '0;
                                        lastf_next[i]  = '0;
                                        limit_next[i]  = '0;
                                    end
                                    else if (armed_reg[i] &&
                                             operation == ptt_pkg::OP_RESTART)
                                    begin
                                        lastf_next[i] = now_time;
                                    end
                                    else if (armed_reg[i])
                                    begin
                                        paused_next[i] = pause_flag;
                                    end
                                end
                            end
                        end
                        else if (id_ext >= usable)
                        begin
                            op_ok = 1'b0;
                        end
                        else if (operation == ptt_pkg::OP_ARM)
                        begin
                            if (!armed_reg[timer_id])
                            begin
                                op_ok                 = 1'b1;
                                armed_next[timer_id]  = 1'b1;
                                period_next[timer_id] = interval;
                                catch_next[timer_id]  = catch_up;
                                limit_next[timer_id]  = eh_sat;
                                paused_next[timer_id] = 1'b0;
                                lastf_next[timer_id]  = now_time;
                            end
                        end
                        else if (armed_reg[timer_id])
                        begin
                            op_ok = 1'b1;
                            unique case (operation)
                                ptt_pkg::OP_SET_IVAL: period_next[timer_id] = interval;
                                ptt_pkg::OP_CLEAR:
                                begin
                                    armed_next[timer_id]  = 1'b0;
                                    paused_next[timer_id] = 1'b0;
                                    catch_next[timer_id]  = 1'b0;
                                    period_next[timer_id] = '0;
                                    lastf_next[timer_id]  = '0;
                                    limit_next[timer_id]  = '0;
                                end
                                ptt_pkg::OP_RESTART:  lastf_next[timer_id] = now_time;
                                default:              paused_next[timer_id] = pause_flag;
                            endcase
                        end
                        done_next = 1'b1;
                        kind_next = ptt_pkg::KIND_STATUS;
                        ok_next   = op_ok;
                        chan_next = '0;
                        time_next = '0;
                        last_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (armed_reg[idx_reg] && !paused_reg[idx_reg] && unit_res.due)
                begin
                    fire_evt = 1'b1;
                    if (!catch_reg[idx_reg])
                    begin
                        lastf_next[idx_reg] = now_reg;
                        advance             = 1'b1;
                    end
                    else
                    begin
                        lastf_next[idx_reg] = unit_res.next_last;
                        hit_next            = '0;
                        state_next          = S_CATCH;
                    end
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_CATCH:
            begin
                if (hit_reg < limit_reg[idx_reg] && unit_res.due)
                begin
                    fire_evt            = 1'b1;
                    lastf_next[idx_reg] = unit_res.next_last;
                    hit_next            = hit_reg + 1'b1;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            default:
            begin
                // close the tick with the held fire event or an empty marker
                done_next       = 1'b1;
                ok_next         = 1'b0;
                last_next       = 1'b1;
                kind_next       = pend_valid_reg ? ptt_pkg::KIND_FIRE : ptt_pkg::KIND_NONE;
                chan_next       = pend_valid_reg ? pend_chan_reg : '0;
                time_next       = pend_valid_reg ? now_reg : '0;
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
        endcase

        // hold the newest fire event back so the final one can carry last
        if (fire_evt)
        begin
            pend_valid_next = 1'b1;
            pend_chan_next  = idx_reg;
            if (pend_valid_reg)
            begin
                done_next = 1'b1;
                kind_next = ptt_pkg::KIND_FIRE;
                ok_next   = 1'b0;
                chan_next = pend_chan_reg;
                time_next = now_reg;
                last_next = 1'b0;
            end
        end

        if (advance)
        begin
            if (idx_ext + 1'b1 == size_reg)
            begin
                state_next = S_FINISH;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            armed_reg      <= '0;
            paused_reg     <= '0;
            catch_reg      <= '0;
            for (int i = 0; i < N; i++)
            begin
                period_reg[i] <= '0;
                lastf_reg[i]  <= '0;
                limit_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
            armed_reg      <= armed_next;
            paused_reg     <= paused_next;
            catch_reg      <= catch_next;
            period_reg     <= period_next;
            lastf_reg      <= lastf_next;
            limit_reg      <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        size_reg      <= size_next;
        hit_reg       <= hit_next;
        now_reg       <= now_next;
        pend_chan_reg <= pend_chan_next;
        kind_reg      <= kind_next;
        ok_reg        <= ok_next;
        chan_reg      <= chan_next;
        time_reg      <= time_next;
        last_reg      <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign kind          = kind_reg;
    assign ok            = ok_reg;
    assign fired_channel = chan_reg;
    assign fire_time     = time_reg;
    assign last          = last_reg;

    `PTT_ASSERT(a_tick_enters_busy, $rose(busy) |-> $past(start) && ($past(operation) == ptt_pkg::OP_TICK), "busy rose without a tick transfer")
    `PTT_ASSERT(a_empty_is_last, done && (kind == ptt_pkg::KIND_NONE) |-> last, "empty tick marker not marked last")
    `PTT_ASSERT(a_scan_in_range, (state_reg == S_SCAN || state_reg == S_CATCH) |-> (idx_ext < size_reg), "scan index beyond usable channels")
    `PTT_ASSERT(a_catch_mode, (state_reg == S_CATCH) |-> catch_reg[idx_reg], "catch-up walk on a filter channel")
    `PTT_ASSERT(a_finish_clears, (state_reg == S_FINISH) |=> !pend_valid_reg && done && last, "tick close did not flush the held event")
endmodule
`default_nettype wire
